// ----- rtl/core/bal_pkg.sv -----
// Package for the bounded array list: sizes, operation and status codes,
// and the per-cell control struct. No dependencies.
package bal_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned INDEX_W  = 5;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned DATA_W   = 32;
  // common width for comparing the count against an index
  localparam int unsigned CMP_W    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH   = 3'd0,
    FN_POP    = 3'd1,
    FN_READ   = 3'd2,
    FN_WRITE  = 3'd3,
    FN_INSERT = 3'd4,
    FN_CLEAR  = 3'd5,
    FN_FRONT  = 3'd6,
    FN_BACK   = 3'd7
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic load;   // take the incoming word
    logic shift;  // take the word of the cell below
  } cell_ctrl_t;

endpackage

// ----- rtl/core/bal_if.sv -----
// Handshake channels of the bounded array list: operation items in,
// result items out. Depends on bal_pkg.
interface bal_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [bal_pkg::FUNC_W-1:0]            func;
  logic [bal_pkg::INDEX_W-1:0]           index;
  logic signed [bal_pkg::DATA_W-1:0]     value;

  modport source (output valid, func, index, value, input ready);
  modport sink   (input valid, func, index, value, output ready);
endinterface

interface bal_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [bal_pkg::DATA_W-1:0]     read_value;
  logic [bal_pkg::COUNT_W-1:0]           count;
  logic [bal_pkg::STATUS_W-1:0]          status;

  modport source (output valid, read_value, count, status, input ready);
  modport sink   (input valid, read_value, count, status, output ready);
endinterface

// ----- rtl/core/bounded_array_list_unit.sv -----
// Top level of the bounded array list: decode, element count, a chain of
// bal_cell storage cells and the result register. Depends on bal_pkg, bal_if, bal_cell.

// The list holds up to CAPACITY signed 32-bit words in a row of cells and
// takes one operation item per clock cycle, insert included: every cell
// loads, shifts from its lower neighbor or holds in the same cycle. The
// result is captured in the output register when the item is taken,
// and a new item is taken whenever that register is empty or being read.
// Elements are not cleared at reset; only the count and the output valid flag are.
module bounded_array_list_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  bal_in_if.sink     in_i,
  bal_out_if.source  out_o
);
  import bal_pkg::*;

  logic                     fire;
  func_e                    func;
  logic [CMP_W-1:0]         idx_ext;
  logic [CMP_W-1:0]         cnt_ext;
  logic                     is_full;
  logic                     is_empty;

  logic [CNT_W-1:0]         count_q;
  logic [CNT_W-1:0]         count_d;
  logic                     store_en;
  logic                     shift_en;
  logic [CMP_W-1:0]         store_pos;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     rd_en;
  status_e                  status;

  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  cell_ctrl_t               cell_ctrl [CAPACITY];

  logic                     out_valid_q;
  logic signed [DATA_W-1:0] read_value_q;
  logic signed [DATA_W-1:0] read_value_d;
  logic [COUNT_W-1:0]       count_out_q;
  status_e                  status_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign fire       = in_i.valid && in_i.ready;
  assign func       = func_e'(in_i.func);
  assign idx_ext    = CMP_W'(in_i.index);
  assign cnt_ext    = CMP_W'(count_q);
  assign is_full    = (cnt_ext == CMP_W'(CAPACITY));
  assign is_empty   = (count_q == '0);

  // operation decode
  always_comb begin
    count_d   = count_q;
    store_en  = 1'b0;
    shift_en  = 1'b0;
    store_pos = idx_ext;
    rd_en     = 1'b0;
    rd_addr   = in_i.index[ADDR_W-1:0];
    status    = ST_OK;
    unique case (func)
      FN_PUSH: begin
        store_pos = cnt_ext;
        if (is_full) begin
          status = ST_FULL;
        end else begin
          store_en = 1'b1;
          count_d  = count_q + 1'b1;
        end
      end
      FN_POP: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      FN_READ: begin
        if (idx_ext >= cnt_ext) begin
          status = ST_RANGE;
        end else begin
          rd_en = 1'b1;
        end
      end
      FN_WRITE: begin
        if (idx_ext >= cnt_ext) begin
          status = ST_RANGE;
        end else begin
          store_en = 1'b1;
        end
      end
      FN_INSERT: begin
        priority if (idx_ext > cnt_ext) begin
          status = ST_RANGE;
        end else if (is_full) begin
          status = ST_FULL;
        end else begin
          store_en = 1'b1;
          shift_en = 1'b1;
          count_d  = count_q + 1'b1;
        end
      end
      FN_CLEAR: begin
        count_d = '0;
      end
      FN_FRONT: begin
        rd_addr = '0;
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          rd_en = 1'b1;
        end
      end
      FN_BACK: begin
        rd_addr = ADDR_W'(count_q - 1'b1);
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          rd_en = 1'b1;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  // chain of cells; cells above the insert point take their lower neighbor
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    localparam logic [CMP_W-1:0] POS = CMP_W'(j);
    logic signed [DATA_W-1:0] prev;

    if (j == 0) begin : g_first
      assign prev = in_i.value;
    end else begin : g_rest
      assign prev = cell_data[j-1];
    end

    always_comb begin
      cell_ctrl[j].load  = fire && store_en && (POS == store_pos);
      cell_ctrl[j].shift = fire && shift_en && (POS > idx_ext) && (POS <= cnt_ext);
    end

    bal_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl[j]),
      .value_i (in_i.value),
      .prev_i  (prev),
      .data_o  (cell_data[j])
    );
  end

  assign read_value_d = rd_en ? cell_data[rd_addr] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        count_q <= count_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      read_value_q <= read_value_d;
      count_out_q  <= COUNT_W'(CMP_W'(count_d));
      status_q     <= status;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.read_value = read_value_q;
  assign out_o.count      = count_out_q;
  assign out_o.status     = status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(count_q) <= CMP_W'(CAPACITY))
    else $error("element count above capacity");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && func == FN_PUSH && !is_full) |=> (count_q == $past(count_q) + 1'b1))
    else $error("accepted push did not grow the count");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && func == FN_CLEAR) |=> (count_q == '0))
    else $error("clear left elements counted");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (out_valid_q && CMP_W'(out_o.count) == CMP_W'(COUNT_W'(CMP_W'(count_q)))))
    else $error("result missing or count mismatch after accepted item");

endmodule

// ----- rtl/core/bal_cell.sv -----
// One storage cell of the list chain: holds one element, loads a new word
// or takes its lower neighbor's word on insert. Depends on bal_pkg.
module bal_cell (
  input  logic                              clk_i,
  input  bal_pkg::cell_ctrl_t               ctrl_i,
  input  logic signed [bal_pkg::DATA_W-1:0] value_i,
  input  logic signed [bal_pkg::DATA_W-1:0] prev_i,
  output logic signed [bal_pkg::DATA_W-1:0] data_o
);
  import bal_pkg::*;

  logic signed [DATA_W-1:0] data_q;
  logic signed [DATA_W-1:0] data_d;

  always_comb begin
    priority if (ctrl_i.load) begin
      data_d = value_i;
    end else if (ctrl_i.shift) begin
      data_d = prev_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- tb/bal_checker.sv -----
// Scoreboard for the bounded array list: watches the operation and result
// channels, keeps its own copy of the list and compares every result item.
// Depends on bal_pkg and bal_if.
module bal_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  bal_in_if           op_mon_i,
  bal_out_if          res_mon_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import bal_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [COUNT_W-1:0]       count;
    status_e                  status;
  } list_result_t;

  logic signed [DATA_W-1:0] list_words [CAPACITY];
  int unsigned              list_len;
  list_result_t             expected_q [$];
  int unsigned              fails = 0;
  int unsigned              pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  // Apply one operation to the shadow list and return the result it gives.
  function automatic list_result_t apply_list_op(func_e fn, logic [INDEX_W-1:0] idx,
                                                 logic signed [DATA_W-1:0] word);
    list_result_t res;
    int unsigned  pos;
    res.read_value = '0;
    res.status     = ST_OK;
    case (fn)
      FN_PUSH: begin
        if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          list_words[list_len] = word;
          list_len++;
        end
      end
      FN_POP: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else list_len--;
      end
      FN_READ: begin
        if (int'(idx) >= list_len) res.status = ST_RANGE;
        else res.read_value = list_words[idx];
      end
      FN_WRITE: begin
        if (int'(idx) >= list_len) res.status = ST_RANGE;
        else list_words[idx] = word;
      end
      FN_INSERT: begin
        // the range check wins over the full check
        if (int'(idx) > list_len) begin
          res.status = ST_RANGE;
        end else if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (pos = list_len; pos > idx; pos--) list_words[pos] = list_words[pos-1];
          list_words[idx] = word;
          list_len++;
        end
      end
      FN_CLEAR: list_len = 0;
      FN_FRONT: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else res.read_value = list_words[0];
      end
      default: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else res.read_value = list_words[list_len-1];
      end
    endcase
    res.count = list_len[COUNT_W-1:0];
    return res;
  endfunction

  task automatic flag_mismatch(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, field, want, got);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    list_result_t pred;
    if (!rst_ni) begin
      list_len = 0;
      expected_q.delete();
    end else begin
      if (res_mon_i.valid && res_mon_i.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result item with none expected", $realtime);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (res_mon_i.read_value !== want.read_value)
            flag_mismatch("read_value", want.read_value, res_mon_i.read_value);
          if (res_mon_i.count !== want.count)
            flag_mismatch("count", DATA_W'(want.count), DATA_W'(res_mon_i.count));
          if (res_mon_i.status !== want.status)
            flag_mismatch("status", DATA_W'(want.status), DATA_W'(res_mon_i.status));
        end
      end
      if (op_mon_i.valid && op_mon_i.ready) begin
        pred       = apply_list_op(func_e'(op_mon_i.func), op_mon_i.index,
                                   op_mon_i.value);
        expected_q = {expected_q, pred};
      end
    end
    pending = expected_q.size();
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the bounded array list testbench: clock, reset, operation stimulus
// and random backpressure; bal_checker does the prediction and comparison.
// Depends on bal_pkg, bal_if, bal_checker and bounded_array_list_unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bal_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned PHASE_ITEMS  = RANDOM_ITEMS / 3;
  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  typedef enum int unsigned {MODE_GROW, MODE_SHRINK, MODE_MIXED} op_mix_e;

  logic        clk;
  logic        rst_n;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatches;
  int unsigned outstanding;

  bal_in_if  op_ch ();
  bal_out_if res_ch ();

  bounded_array_list_unit i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (op_ch),
    .out_o  (res_ch)
  );

  bal_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .op_mon_i     (op_ch),
    .res_mon_i    (res_ch),
    .fail_count_o (mismatches),
    .pending_o    (outstanding)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #200us;
    $display("simulation failed");
    $finish;
  end

  // result side backpressure
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(func_e fn, int unsigned idx, logic signed [DATA_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      op_ch.valid <= 1'b0;
      @(negedge clk);
    end
    op_ch.valid <= 1'b1;
    op_ch.func  <= fn;
    op_ch.index <= idx[INDEX_W-1:0];
    op_ch.value <= word;
    do @(posedge clk); while (!op_ch.ready);
    @(negedge clk);
  endtask

  // Hold off the sender until every result item has come back.
  task automatic drain_results();
    op_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(9))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_index();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) return $urandom_range(4);
    if (roll < 85) return $urandom_range(16);
    return $urandom_range(31);
  endfunction

  function automatic func_e pick_func(op_mix_e mix);
    int unsigned roll;
    roll = $urandom_range(99);
    case (mix)
      MODE_GROW: begin
        if (roll < 35) return FN_PUSH;
        if (roll < 60) return FN_INSERT;
        if (roll < 72) return FN_READ;
        if (roll < 82) return FN_WRITE;
        if (roll < 87) return FN_FRONT;
        if (roll < 92) return FN_BACK;
        if (roll < 99) return FN_POP;
        return FN_CLEAR;
      end
      MODE_SHRINK: begin
        if (roll < 40) return FN_POP;
        if (roll < 52) return FN_READ;
        if (roll < 62) return FN_WRITE;
        if (roll < 70) return FN_PUSH;
        if (roll < 78) return FN_INSERT;
        if (roll < 86) return FN_FRONT;
        if (roll < 95) return FN_BACK;
        return FN_CLEAR;
      end
      default: begin
        if (roll < 14) return FN_PUSH;
        if (roll < 28) return FN_POP;
        if (roll < 42) return FN_READ;
        if (roll < 56) return FN_WRITE;
        if (roll < 70) return FN_INSERT;
        if (roll < 82) return FN_FRONT;
        if (roll < 94) return FN_BACK;
        return FN_CLEAR;
      end
    endcase
  endfunction

  initial begin
    op_mix_e     mix;
    int unsigned roll;
    rst_n         = 1'b0;
    op_ch.valid   = 1'b0;
    op_ch.func    = FN_PUSH;
    op_ch.index   = '0;
    op_ch.value   = '0;
    send_idle_pct = 24;
    recv_idle_pct = 69;
    mix           = MODE_GROW;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty list corner cases
    send_item(FN_POP, 0, '0);
    send_item(FN_FRONT, 0, '0);
    send_item(FN_BACK, 0, '0);
    send_item(FN_READ, 0, '0);
    send_item(FN_WRITE, 0, 32'sh1111_1111);
    send_item(FN_INSERT, 1, 32'sh2222_2222);
    // insert at the end, then at the head to move the first word up
    send_item(FN_INSERT, 0, WORD_MIN);
    send_item(FN_INSERT, 0, WORD_MAX);
    send_item(FN_READ, 1, '0);
    send_item(FN_WRITE, 1, -1);
    send_item(FN_FRONT, 0, '0);
    send_item(FN_BACK, 0, '0);
    // fill up, then hit the full and range checks
    for (int k = 0; k < 14; k++) send_item(FN_PUSH, 0, $urandom);
    send_item(FN_PUSH, 0, 32'sh5a5a_5a5a);
    send_item(FN_INSERT, 17, 32'sh3333_3333);
    send_item(FN_INSERT, 5, 32'sh4444_4444);
    send_item(FN_READ, 31, '0);
    send_item(FN_READ, 15, '0);
    send_item(FN_CLEAR, 0, '0);
    send_item(FN_BACK, 0, '0);

    for (int phase = 0; phase < 3; phase++) begin
      drain_results();
      send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 69 : 0;
      recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 24 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 24 == 0) begin
          roll = $urandom_range(9);
          mix  = (roll < 5) ? MODE_GROW : (roll < 8) ? MODE_SHRINK : MODE_MIXED;
        end
        send_item(pick_func(mix), pick_index(), pick_word());
      end
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/bal_pkg.sv
rtl/core/bal_if.sv
rtl/core/bal_cell.sv
rtl/core/bounded_array_list_unit.sv
tb/bal_checker.sv
tb/testbench.sv
